// ===== hdl/pisd_pkg.sv =====
`timescale 1ns / 1ps

package pisd_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int BYTE_W      = 8;
  localparam int ID_W        = 56;
  localparam int CAP_W       = 24;
  localparam int SLOT_W      = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFIX_FIRST  = 2'd0,
    REG_PREFIX_SECOND = 2'd1,
    REG_PREFIX_THIRD  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } prefix_t;

  // Search token that travels down the cell chain.
  typedef struct packed {
    logic             active;
    logic             found;
    logic [ID_W-1:0]  key;
    logic [IDX_W-1:0] slot;
  } tok_t;

  typedef struct packed {
    logic [ID_W-1:0]   id_value;
    logic              is_new;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
  } res_t;

  // Low slot bits of a table index, zero-extended for shallow tables.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ===== hdl/pisd_if.sv =====
`timescale 1ns / 1ps

interface pisd_in_if;
  import pisd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface pisd_out_if;
  import pisd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   id_value;
  logic              is_new;
  logic [SLOT_W-1:0] slot;
  logic              table_full;

  modport source (output valid, output id_value, output is_new, output slot,
                  output table_full, input ready);
  modport sink (input valid, input id_value, input is_new, input slot,
                input table_full, output ready);
endinterface

// ===== hdl/pisd_matcher.sv =====
`timescale 1ns / 1ps

module pisd_matcher (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [pisd_pkg::BYTE_W-1:0] byte_i,
  input  pisd_pkg::prefix_t        prefix_i,
  output logic                     done_o,
  output logic [pisd_pkg::ID_W-1:0] id_o
);
  import pisd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3
  } stage_e;

  stage_e           stage_q, stage_d;
  logic [CAP_W-1:0] cap_q, cap_d;

  always_comb begin
    stage_d = stage_q;
    cap_d   = cap_q;
    done_o  = 1'b0;
    id_o    = {prefix_i.first, prefix_i.second, prefix_i.third, cap_q, byte_i};
    if (accept_i) begin
      priority if (byte_i == prefix_i.first) begin
        stage_d = ST_P1;
      end else if (byte_i == prefix_i.second && stage_q == ST_P1) begin
        stage_d = ST_P2;
      end else if (byte_i == prefix_i.third && stage_q == ST_P2) begin
        stage_d = ST_C0;
      end else begin
        unique case (stage_q)
          ST_C0: begin
            cap_d   = {cap_q[CAP_W-BYTE_W-1:0], byte_i};
            stage_d = ST_C1;
          end
          ST_C1: begin
            cap_d   = {cap_q[CAP_W-BYTE_W-1:0], byte_i};
            stage_d = ST_C2;
          end
          ST_C2: begin
            cap_d   = {cap_q[CAP_W-BYTE_W-1:0], byte_i};
            stage_d = ST_C3;
          end
          ST_C3: begin
            done_o  = 1'b1;
            stage_d = ST_IDLE;
          end
          default: begin
            stage_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      cap_q   <= '0;
    end else begin
      stage_q <= stage_d;
      cap_q   <= cap_d;
    end
  end

endmodule

// ===== hdl/pisd_cell.sv =====
`timescale 1ns / 1ps

module pisd_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pisd_pkg::IDX_W-1:0]   idx_i,
  input  logic [pisd_pkg::COUNT_W-1:0] count_i,
  input  logic                         wr_en_i,
  input  logic [pisd_pkg::ID_W-1:0]    wr_data_i,
  input  pisd_pkg::tok_t               tok_i,
  output pisd_pkg::tok_t               tok_o
);
  import pisd_pkg::*;

  logic [ID_W-1:0] entry_q;
  logic            used;
  logic            hit;
  tok_t            tok_d;
  tok_t            tok_q;

  assign used = count_i > COUNT_W'(idx_i);
  assign hit  = tok_i.active && !tok_i.found && used && (entry_q == tok_i.key);

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found | hit;
    tok_d.slot  = hit ? idx_i : tok_i.slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && count_i == COUNT_W'(idx_i)) begin
      entry_q <= wr_data_i;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/prefix_id_scanner_dedup_unit.sv =====
`timescale 1ns / 1ps

// Scans a byte stream for the three-byte prefix held in the configuration
// registers, captures the following four bytes and checks the resulting
// 56-bit identifier against a table of up to TABLE_DEPTH unique identifiers,
// appending it when it is new. A byte that completes an identifier starts
// a search that walks a chain of TABLE_DEPTH compare cells, one cell per
// cycle, each cell holding one table entry; new bytes are held off until
// the result has been placed in the output register or its skid stage.
// While a result waits in the skid stage, input bytes are held off as well.
// No clearing pass is needed after reset.

module prefix_id_scanner_dedup_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pisd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pisd_pkg::BYTE_W-1:0]    cfg_data_i,
  pisd_in_if.sink                        in_i,
  pisd_out_if.source                     out_o
);
  import pisd_pkg::*;

  prefix_t          prefix_q;
  logic             busy_q;
  logic [COUNT_W-1:0] count_q;
  logic             out_valid_q;
  res_t             out_q;
  logic             skid_valid_q;
  res_t             skid_q;

  logic             accept;
  logic             done;
  logic [ID_W-1:0]  id;
  tok_t             head;
  tok_t             chain [TABLE_DEPTH];
  tok_t             tail;
  logic             has_room;
  logic             wr_en;
  res_t             res;
  logic             out_free;

  assign in_i.ready = !busy_q && !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  pisd_matcher u_matcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.data_byte),
    .prefix_i (prefix_q),
    .done_o   (done),
    .id_o     (id)
  );

  always_comb begin
    head.active = accept && done;
    head.found  = 1'b0;
    head.key    = id;
    head.slot   = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tok_t tok_in;
    if (g == 0) begin : g_first
      assign tok_in = head;
    end else begin : g_next
      assign tok_in = chain[g-1];
    end
    pisd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .count_i   (count_q),
      .wr_en_i   (wr_en),
      .wr_data_i (tail.key),
      .tok_i     (tok_in),
      .tok_o     (chain[g])
    );
  end

  assign tail     = chain[TABLE_DEPTH-1];
  assign has_room = count_q < COUNT_W'(TABLE_DEPTH);
  assign wr_en    = tail.active && !tail.found && has_room;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    res.id_value = tail.key;
    if (tail.found) begin
      res.is_new     = 1'b0;
      res.slot       = to_slot(tail.slot);
      res.table_full = 1'b0;
    end else if (has_room) begin
      res.is_new     = 1'b1;
      res.slot       = to_slot(count_q[IDX_W-1:0]);
      res.table_full = 1'b0;
    end else begin
      res.is_new     = 1'b1;
      res.slot       = '0;
      res.table_full = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q     <= '1;
      busy_q       <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PREFIX_FIRST:  prefix_q.first  <= cfg_data_i;
          REG_PREFIX_SECOND: prefix_q.second <= cfg_data_i;
          REG_PREFIX_THIRD:  prefix_q.third  <= cfg_data_i;
          default: ;
        endcase
      end
      if (head.active) begin
        busy_q <= 1'b1;
      end else if (tail.active) begin
        busy_q <= 1'b0;
      end
      if (wr_en) begin
        count_q <= count_q + COUNT_W'(1);
      end
      priority if (tail.active) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (skid_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (tail.active) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (skid_valid_q && out_free) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.id_value   = out_q.id_value;
  assign out_o.is_new     = out_q.is_new;
  assign out_o.slot       = out_q.slot;
  assign out_o.table_full = out_q.table_full;

endmodule

// ===== hdl/pisd_checker.sv =====
`timescale 1ns / 1ps

module pisd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [pisd_pkg::ID_W-1:0]     out_id_value_i,
  input logic                          out_is_new_i,
  input logic [pisd_pkg::SLOT_W-1:0]   out_slot_i,
  input logic                          out_table_full_i
);
  import pisd_pkg::*;

  // A stalled item keeps its identifier.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_value_i))
    else $error("Output item changed while stalled.");

  // A dropped identifier is always reported as new with slot zero.
  a_full_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_table_full_i |-> out_is_new_i && out_slot_i == '0)
    else $error("Table full flag without new identifier or with nonzero slot.");

  // A result only appears after the input side was held off for the search.
  a_search_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("Result appeared without a preceding search.");

endmodule

bind prefix_id_scanner_dedup_unit pisd_checker u_pisd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_id_value_i   (out_o.id_value),
  .out_is_new_i     (out_o.is_new),
  .out_slot_i       (out_o.slot),
  .out_table_full_i (out_o.table_full)
);
